@@ sv/sidac_pkg.sv @@
`default_nettype none
package sidac_pkg;
	localparam int unsigned ValueWidth = 32;
	localparam int unsigned NumDigits = 10;
	localparam int unsigned BcdWidth = 4 * NumDigits;
	localparam int unsigned DabbleSteps = 8;
	localparam int unsigned NumStages = ValueWidth / DabbleSteps;
	localparam logic [6:0] AsciiZero = 7'd48;
	localparam logic [6:0] AsciiMinus = 7'd45;

	typedef struct packed {
		logic neg;
		logic [BcdWidth-1:0] bcd;
		logic [ValueWidth-1:0] bin;
	} sidac_word_t;
endpackage
`default_nettype wire

@@ sv/sidac_stage.sv @@
`default_nettype none
module sidac_stage (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input sidac_pkg::sidac_word_t in_word,
	output logic out_valid,
	input wire logic out_ready,
	output sidac_pkg::sidac_word_t out_word
);
	import sidac_pkg::*;

	sidac_word_t next_word;
	sidac_word_t word_s1;
	logic valid_s1;

	always_comb begin
		next_word = in_word;
		for (int s = 0; s < DabbleSteps; s++) begin
			for (int d = 0; d < NumDigits; d++) begin
				if (next_word.bcd[4*d +: 4] >= 4'd5) begin
					next_word.bcd[4*d +: 4] = next_word.bcd[4*d +: 4] + 4'd3;
				end
			end
			{next_word.bcd, next_word.bin} = {next_word.bcd, next_word.bin} << 1;
		end
	end

	assign in_ready = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= next_word;
		end
	end
endmodule
`default_nettype wire

@@ sv/signed_int_to_decimal_ascii.sv @@
// The character serializer at the end of the pipeline sends one character per cycle
// while m_tready is high, so it sets the rate at which values are taken.
// Four binary-to-BCD stages of eight shift steps each follow the magnitude stage.
// Reset is asynchronous and active low and clears all valid and busy flags.
`default_nettype none
module signed_int_to_decimal_ascii (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // value[31:0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // ascii_char[6:0], zero[7]
	output logic m_tlast
);
	import sidac_pkg::*;

	sidac_word_t word_s1;
	logic valid_s1;
	logic ready_s1;
	logic [NumStages:0] valid_c;
	logic [NumStages:0] ready_c;
	sidac_word_t word_c [NumStages+1];

	logic busy_q;
	logic neg_q;
	logic [BcdWidth-1:0] bcd_q;
	logic [3:0] idx_q;
	logic [3:0] top_digit;
	logic done;
	logic load_ok;

	assign ready_s1 = ready_c[0];
	assign s_tready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1.neg <= s_tdata[31];
			word_s1.bcd <= '0;
			word_s1.bin <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
		end
	end

	assign valid_c[0] = valid_s1;
	assign word_c[0] = word_s1;

	for (genvar g = 0; g < NumStages; g++) begin : g_stage
		sidac_stage u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(valid_c[g]),
			.in_ready(ready_c[g]),
			.in_word(word_c[g]),
			.out_valid(valid_c[g+1]),
			.out_ready(ready_c[g+1]),
			.out_word(word_c[g+1])
		);
	end

	assign done = m_tready && !neg_q && (idx_q == 4'd0);
	assign load_ok = !busy_q || done;
	assign ready_c[NumStages] = load_ok;

	always_comb begin
		top_digit = 4'd0;
		for (int d = 0; d < NumDigits; d++) begin
			if (word_c[NumStages].bcd[4*d +: 4] != 4'd0) begin
				top_digit = 4'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q <= 1'b0;
			idx_q <= 4'd0;
		end else if (load_ok) begin
			busy_q <= valid_c[NumStages];
			neg_q <= valid_c[NumStages] && word_c[NumStages].neg;
			idx_q <= top_digit;
		end else if (m_tready) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && valid_c[NumStages]) begin
			bcd_q <= word_c[NumStages].bcd;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata = {1'b0, neg_q ? AsciiMinus : (AsciiZero + {3'd0, bcd_q[4*idx_q +: 4]})};
	assign m_tlast = !neg_q && (idx_q == 4'd0);
endmodule
`default_nettype wire

@@ sv/sidac_checker.sv @@
`default_nettype none
module sidac_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic m_tlast
);
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata == 8'd45 || (m_tdata >= 8'd48 && m_tdata <= 8'd57))
		else $error("output character out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata == 8'd45 |-> !m_tlast)
		else $error("minus sign marked as last");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata == 8'd45 |=> m_tvalid && m_tdata != 8'd45)
		else $error("minus sign not followed by a digit");
endmodule

bind signed_int_to_decimal_ascii sidac_checker u_sidac_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);
`default_nettype wire

@@ dv/signed_int_to_decimal_ascii_tb.sv @@
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_tb;
	import sidac_pkg::*;

	typedef struct {
		logic [6:0] ch;
		logic last;
	} char_t;

	typedef struct {
		logic [31:0] value;
		string text;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;

	char_t pending_chars[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_sink = 1'b0;
	bit stim_done = 1'b0;

	localparam int IdleLimit = 20000;

	signed_int_to_decimal_ascii u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	function automatic void push_decimal(logic [31:0] value);
		logic [31:0] mag;
		logic [3:0] digits[10];
		int nd;
		char_t c;
		nd = 0;
		mag = value[31] ? (32'd0 - value) : value;
		do begin
			digits[nd] = 4'(mag % 10);
			mag = mag / 10;
			nd++;
		end while (mag != 0);
		if (value[31]) begin
			c.ch = AsciiMinus;
			c.last = 1'b0;
			pending_chars.push_back(c);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			c.ch = AsciiZero + 7'(digits[i]);
			c.last = (i == 0);
			pending_chars.push_back(c);
		end
	endfunction

	function automatic void push_text(string text);
		char_t c;
		for (int i = 0; i < text.len(); i++) begin
			c.ch = 7'(text[i]);
			c.last = (i == text.len() - 1);
			pending_chars.push_back(c);
		end
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_value(logic [31:0] value, string text);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (text.len() > 0) begin
			push_text(text);
		end else begin
			push_decimal(value);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] random_value();
		int k;
		logic [31:0] v;
		k = $urandom_range(0, 9);
		v = $urandom();
		case (k)
			0: v = 32'($urandom_range(0, 9));
			1: v = 32'($urandom_range(0, 999));
			2: v = -32'($urandom_range(1, 999));
			3: v = v >> $urandom_range(0, 31);
			4: v = -(v >> $urandom_range(1, 31));
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		vector_t table_rows[$];
		table_rows = '{
			'{32'd0, "0"},
			'{32'd1, "1"},
			'{32'hFFFF_FFFF, "-1"},
			'{32'd9, "9"},
			'{32'd10, "10"},
			'{-32'd10, "-10"},
			'{32'h7FFF_FFFF, "2147483647"},
			'{32'h8000_0000, "-2147483648"},
			'{32'h8000_0001, "-2147483647"},
			'{32'd1000000000, "1000000000"},
			'{32'd999999999, ""},
			'{32'hAAAA_AAAA, ""},
			'{32'h5555_5555, ""},
			'{32'd4294967286, ""},
			'{32'd12345, ""},
			'{32'd100, ""}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (table_rows[i]) begin
			send_value(table_rows[i].value, table_rows[i].text);
		end
		s_tvalid <= 1'b0;
		wait (pending_chars.size() == 0);
		@(posedge clk);
		hold_req <= 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_value(random_value(), "");
		end
		for (int i = 0; i < 82; i++) begin
			send_value(random_value(), "");
			if (i == 50) begin
				s_tvalid <= 1'b0;
				wait (pending_chars.size() == 0);
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		stim_done <= 1'b1;
	end

	initial begin
		wait (hold_req);
		hold_sink <= 1'b1;
		repeat (200) @(posedge clk);
		hold_sink <= 1'b0;
	end

	always @(posedge clk) begin
		if (!hold_sink && ($urandom_range(0, 99) < 70 || $urandom_range(0, 3) == 0)) begin
			m_tready <= ($urandom_range(0, 19) != 0) || m_tready;
		end else begin
			m_tready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		char_t exp_c;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character %0d", m_tdata[6:0]);
				errors++;
			end else begin
				exp_c = pending_chars.pop_front();
				if (m_tdata[6:0] !== exp_c.ch) begin
					$error("ascii_char expected %0d actual %0d", exp_c.ch, m_tdata[6:0]);
					errors++;
				end
				if (m_tlast !== exp_c.last) begin
					$error("last expected %0b actual %0b", exp_c.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_chars.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0 && pending_chars.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end
endmodule
